// ===== rtl/ubrf_pkg.sv =====
// ----------------------------------------------------------------------------
// ubrf_pkg
// Shared constants, command codes and control types for the UART ring FIFOs.
// ----------------------------------------------------------------------------
package ubrf_pkg;

  // Default ring depth in slots. It must be a power of two from 2 to 256.
  localparam int unsigned FIFO_DEPTH = 64;

  // Payload widths.
  localparam int unsigned DATA_W = 8;
  localparam int unsigned CMD_W  = 2;

  // Commands carried by one input beat.
  typedef enum logic [CMD_W-1:0] {
    CMD_HOST_WRITE = 2'd0,
    CMD_HOST_READ  = 2'd1,
    CMD_RX_BYTE    = 2'd2,
    CMD_TX_READY   = 2'd3
  } cmd_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // latch the input beat
    logic exec;     // update the rings and issue the storage access
    logic publish;  // load the output register
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free; // the output register can take a result this cycle
  } dp_status_t;

endpackage

// ===== rtl/ubrf_ram.sv =====
// ----------------------------------------------------------------------------
// ubrf_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ubrf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/ubrf_ctrl.sv =====
// ----------------------------------------------------------------------------
// ubrf_ctrl
// Sequencer that steps one command at a time through capture, ring update
// and result load.
// ----------------------------------------------------------------------------
module ubrf_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  ubrf_pkg::dp_status_t status,
  output ubrf_pkg::dp_cmd_t    cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_FIN
  } state_t;

  state_t state;

  // Decode the datapath commands from the current state.
  always_comb begin
    cmd.capture = in_valid && in_ready;
    cmd.exec    = (state == S_EXEC);
    cmd.publish = (state == S_FIN) && status.out_free;
  end

  // State and the registered input ready.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      in_ready <= 1'b1;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state    <= S_EXEC;
            in_ready <= 1'b0;
          end
        end
        S_EXEC: begin
          state <= S_FIN;
        end
        S_FIN: begin
          if (status.out_free) begin
            state    <= S_IDLE;
            in_ready <= 1'b1;
          end
        end
        default: begin
          state    <= S_IDLE;
          in_ready <= 1'b1;
        end
      endcase
    end
  end

endmodule

// ===== rtl/ubrf_datapath.sv =====
// ----------------------------------------------------------------------------
// ubrf_datapath
// Ring pointers, interrupt enable, both ring stores and the output register.
// ----------------------------------------------------------------------------
module ubrf_datapath #(
  parameter int unsigned FIFO_DEPTH = ubrf_pkg::FIFO_DEPTH,
  parameter int unsigned PTR_W = $clog2(FIFO_DEPTH)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  ubrf_pkg::dp_cmd_t            cmd,
  output ubrf_pkg::dp_status_t         status,
  input  logic [ubrf_pkg::CMD_W-1:0]  command,
  input  logic [ubrf_pkg::DATA_W-1:0] data_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        accepted,
  output logic [ubrf_pkg::DATA_W-1:0] read_byte,
  output logic                        send_valid,
  output logic [ubrf_pkg::DATA_W-1:0] send_byte,
  output logic                        tx_irq_enable,
  output logic                        rx_available,
  output logic                        rx_dropped
);

  // Captured input beat.
  ubrf_pkg::cmd_e                cmd_q;
  logic [ubrf_pkg::DATA_W-1:0]   data_q;

  // Ring state.
  logic [PTR_W-1:0] tx_head;
  logic [PTR_W-1:0] tx_tail;
  logic [PTR_W-1:0] rx_head;
  logic [PTR_W-1:0] rx_tail;
  logic             irq_enable_flag;

  // Per-item results held between the ring update and the output load.
  logic res_accepted;
  logic res_read_sel;
  logic res_send;
  logic res_dropped;

  // Ring conditions and storage access.
  logic [PTR_W-1:0] tx_head_inc;
  logic [PTR_W-1:0] tx_tail_inc;
  logic [PTR_W-1:0] rx_head_inc;
  logic [PTR_W-1:0] rx_tail_inc;
  logic tx_full;
  logic tx_empty;
  logic rx_full;
  logic rx_empty;
  logic tx_we;
  logic tx_re;
  logic rx_we;
  logic rx_re;
  logic [ubrf_pkg::DATA_W-1:0] tx_rdata;
  logic [ubrf_pkg::DATA_W-1:0] rx_rdata;

  // Indices wrap by truncation since the depth is a power of two.
  assign tx_head_inc = tx_head + PTR_W'(1);
  assign tx_tail_inc = tx_tail + PTR_W'(1);
  assign rx_head_inc = rx_head + PTR_W'(1);
  assign rx_tail_inc = rx_tail + PTR_W'(1);

  // One slot stays empty, so full means the head is one behind the tail.
  assign tx_full  = (tx_head_inc == tx_tail);
  assign tx_empty = (tx_head == tx_tail);
  assign rx_full  = (rx_head_inc == rx_tail);
  assign rx_empty = (rx_head == rx_tail);

  // Storage accesses happen in the ring update cycle only.
  assign tx_we = cmd.exec && (cmd_q == ubrf_pkg::CMD_HOST_WRITE) && !tx_full;
  assign tx_re = cmd.exec && (cmd_q == ubrf_pkg::CMD_TX_READY) && !tx_empty;
  assign rx_we = cmd.exec && (cmd_q == ubrf_pkg::CMD_RX_BYTE) && !rx_full;
  assign rx_re = cmd.exec && (cmd_q == ubrf_pkg::CMD_HOST_READ) && !rx_empty;

  assign status.out_free = !out_valid || out_ready;

  ubrf_ram #(
    .WIDTH  (ubrf_pkg::DATA_W),
    .DEPTH  (FIFO_DEPTH),
    .ADDR_W (PTR_W)
  ) u_tx_store (
    .clk   (clk),
    .we    (tx_we),
    .waddr (tx_head),
    .wdata (data_q),
    .re    (tx_re),
    .raddr (tx_tail),
    .rdata (tx_rdata)
  );

  ubrf_ram #(
    .WIDTH  (ubrf_pkg::DATA_W),
    .DEPTH  (FIFO_DEPTH),
    .ADDR_W (PTR_W)
  ) u_rx_store (
    .clk   (clk),
    .we    (rx_we),
    .waddr (rx_head),
    .wdata (data_q),
    .re    (rx_re),
    .raddr (rx_tail),
    .rdata (rx_rdata)
  );

  // Input beat capture.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_q  <= ubrf_pkg::cmd_e'(command);
      data_q <= data_byte;
    end
  end

  // Ring update: pointers, interrupt enable and per-item result flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      tx_head         <= '0;
      tx_tail         <= '0;
      rx_head         <= '0;
      rx_tail         <= '0;
      irq_enable_flag <= 1'b0;
      res_accepted    <= 1'b0;
      res_read_sel    <= 1'b0;
      res_send        <= 1'b0;
      res_dropped     <= 1'b0;
    end else if (cmd.exec) begin
      res_accepted <= 1'b0;
      res_read_sel <= 1'b0;
      res_send     <= 1'b0;
      res_dropped  <= 1'b0;
      unique case (cmd_q)
        ubrf_pkg::CMD_HOST_WRITE: begin
          // A rejected write still arms the interrupt.
          if (!tx_full) begin
            tx_head      <= tx_head_inc;
            res_accepted <= 1'b1;
          end
          irq_enable_flag <= 1'b1;
        end
        ubrf_pkg::CMD_HOST_READ: begin
          if (!rx_empty) begin
            rx_tail      <= rx_tail_inc;
            res_accepted <= 1'b1;
            res_read_sel <= 1'b1;
          end
        end
        ubrf_pkg::CMD_RX_BYTE: begin
          if (!rx_full) begin
            rx_head <= rx_head_inc;
          end else begin
            res_dropped <= 1'b1;
          end
        end
        ubrf_pkg::CMD_TX_READY: begin
          // Nothing left to send disarms the interrupt.
          if (!tx_empty) begin
            tx_tail  <= tx_tail_inc;
            res_send <= 1'b1;
          end else begin
            irq_enable_flag <= 1'b0;
          end
        end
        default: begin
          res_accepted <= 1'b0;
        end
      endcase
    end
  end

  // Output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.publish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output payload register; store read data arrives in this cycle.
  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      accepted      <= res_accepted;
      read_byte     <= res_read_sel ? rx_rdata : '0;
      send_valid    <= res_send;
      send_byte     <= res_send ? tx_rdata : '0;
      tx_irq_enable <= irq_enable_flag;
      rx_available  <= !rx_empty;
      rx_dropped    <= res_dropped;
    end
  end

endmodule

// ===== rtl/uart_buffered_ring_fifos_unit.sv =====
// ----------------------------------------------------------------------------
// uart_buffered_ring_fifos_unit
// Host-side UART buffering with a transmit ring and a receive ring.
// ----------------------------------------------------------------------------
// Each input beat carries one command: host write, host read, byte received
// or transmitter ready. Both rings hold FIFO_DEPTH - 1 bytes in block RAM.
// An accepted beat is captured, then the ring pointers are updated and the
// ring store is accessed, and then the registered store read is loaded
// into the output register once that register is free. One item is in
// flight at a time, so a new beat is not accepted until the last result
// is loaded. The output register lets the next beat be accepted while a
// result waits. The rings need no clearing after reset, since a slot is
// only read after it was written.
module uart_buffered_ring_fifos_unit #(
  parameter int unsigned FIFO_DEPTH = ubrf_pkg::FIFO_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [ubrf_pkg::CMD_W-1:0]  command,
  input  logic [ubrf_pkg::DATA_W-1:0] data_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        accepted,
  output logic [ubrf_pkg::DATA_W-1:0] read_byte,
  output logic                        send_valid,
  output logic [ubrf_pkg::DATA_W-1:0] send_byte,
  output logic                        tx_irq_enable,
  output logic                        rx_available,
  output logic                        rx_dropped
);

  localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);

  ubrf_pkg::dp_cmd_t    dp_cmd;
  ubrf_pkg::dp_status_t dp_status;

  ubrf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (dp_status),
    .cmd      (dp_cmd)
  );

  ubrf_datapath #(
    .FIFO_DEPTH (FIFO_DEPTH),
    .PTR_W      (PTR_W)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (dp_cmd),
    .status        (dp_status),
    .command       (command),
    .data_byte     (data_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .accepted      (accepted),
    .read_byte     (read_byte),
    .send_valid    (send_valid),
    .send_byte     (send_byte),
    .tx_irq_enable (tx_irq_enable),
    .rx_available  (rx_available),
    .rx_dropped    (rx_dropped)
  );

  // Only one item is in flight: an accepted beat closes the input.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while an item is still in flight");

  // A byte handed to the line never comes with host or drop flags.
  a_send_exclusive: assert property (@(posedge clk) disable iff (rst)
    (out_valid && send_valid) |-> (!accepted && !rx_dropped))
    else $error("send result mixed with another command's flags");

  // Unused byte fields read as zero.
  a_zero_bytes: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((accepted || read_byte == '0) && (send_valid || send_byte == '0)))
    else $error("byte field is nonzero without a matching flag");

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the UART transmit and receive ring buffers.
// ----------------------------------------------------------------------------
// Command beats go in over a valid/ready channel. A behavioral copy of both
// rings predicts the status beat that each command produces. Each status beat
// that comes out is compared field by field against the oldest prediction.
// Directed beats cover empty rings and byte extremes. Fill and drain runs push
// both rings to full and back to empty. A long output hold-off makes the
// unit stall its input. Random mixes with and without idle gaps close the run.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FIFO_DEPTH   = ubrf_pkg::FIFO_DEPTH;
  localparam int unsigned DATA_W       = ubrf_pkg::DATA_W;
  localparam int unsigned CMD_W        = ubrf_pkg::CMD_W;
  localparam int unsigned IDX_W        = $clog2(FIFO_DEPTH);
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned HOLD_CYCLES  = 160;
  localparam int unsigned LIMIT_CYCLES = 200000;
  localparam int unsigned IDLE_PCT     = 28;

  typedef logic [IDX_W-1:0] ring_idx_t;

  // One status beat as the unit reports it.
  typedef struct packed {
    logic              accepted;
    logic [DATA_W-1:0] read_byte;
    logic              send_valid;
    logic [DATA_W-1:0] send_byte;
    logic              tx_irq_enable;
    logic              rx_available;
    logic              rx_dropped;
  } ring_status_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [CMD_W-1:0]  command = '0;
  logic [DATA_W-1:0] data_byte = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              accepted;
  logic [DATA_W-1:0] read_byte;
  logic              send_valid;
  logic [DATA_W-1:0] send_byte;
  logic              tx_irq_enable;
  logic              rx_available;
  logic              rx_dropped;

  // Behavioral copy of both rings and the interrupt enable.
  logic [DATA_W-1:0] tx_ring [FIFO_DEPTH];
  logic [DATA_W-1:0] rx_ring [FIFO_DEPTH];
  ring_idx_t         tx_wr = '0;
  ring_idx_t         tx_rd = '0;
  ring_idx_t         rx_wr = '0;
  ring_idx_t         rx_rd = '0;
  logic              irq_en = 1'b0;

  ring_status_t status_due [$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          hold_request = 1'b0;
  int unsigned hold_left = 0;
  int unsigned cycle_count = 0;
  int unsigned beats_sent = 0;
  int unsigned status_checked = 0;
  int unsigned mismatch_count = 0;
  int unsigned tx_rejects = 0;
  int unsigned rx_drops = 0;
  int unsigned stall_cycles = 0;

  uart_buffered_ring_fifos_unit dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .command      (command),
    .data_byte    (data_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .accepted     (accepted),
    .read_byte    (read_byte),
    .send_valid   (send_valid),
    .send_byte    (send_byte),
    .tx_irq_enable(tx_irq_enable),
    .rx_available (rx_available),
    .rx_dropped   (rx_dropped)
  );

  always #2 clk = ~clk;

  // Apply one command to the ring copy and queue the status it must produce.
  task automatic advance_rings(input ubrf_pkg::cmd_e cmd, input logic [DATA_W-1:0] value);
    ring_status_t s;
    ring_idx_t    nxt;
    s = '0;
    case (cmd)
      ubrf_pkg::CMD_HOST_WRITE: begin
        nxt = tx_wr + 1'b1;
        if (nxt != tx_rd) begin
          tx_ring[tx_wr] = value;
          tx_wr = nxt;
          s.accepted = 1'b1;
        end else begin
          tx_rejects++;
        end
        irq_en = 1'b1;
      end
      ubrf_pkg::CMD_HOST_READ: begin
        if (rx_wr != rx_rd) begin
          s.read_byte = rx_ring[rx_rd];
          rx_rd = rx_rd + 1'b1;
          s.accepted = 1'b1;
        end
      end
      ubrf_pkg::CMD_RX_BYTE: begin
        nxt = rx_wr + 1'b1;
        if (nxt != rx_rd) begin
          rx_ring[rx_wr] = value;
          rx_wr = nxt;
        end else begin
          s.rx_dropped = 1'b1;
          rx_drops++;
        end
      end
      default: begin
        if (tx_rd != tx_wr) begin
          s.send_byte = tx_ring[tx_rd];
          s.send_valid = 1'b1;
          tx_rd = tx_rd + 1'b1;
        end else begin
          irq_en = 1'b0;
        end
      end
    endcase
    s.tx_irq_enable = irq_en;
    s.rx_available = (rx_wr != rx_rd);
    status_due.push_back(s);
  endtask

  // Offer one command beat and hold it until the unit takes it.
  task automatic send_beat(input ubrf_pkg::cmd_e cmd, input logic [DATA_W-1:0] value);
    @(negedge clk);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    command   <= cmd;
    data_byte <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    beats_sent++;
    advance_rings(cmd, value);
  endtask

  // Stop offering beats and wait until every predicted status has come back.
  task automatic wait_until_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (status_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Random commands; the weights are percentages, transmitter ready takes the rest.
  task automatic run_mix(input int unsigned n, input int unsigned pw,
                         input int unsigned pr, input int unsigned prx);
    int unsigned       r;
    logic [DATA_W-1:0] value;
    for (int unsigned i = 0; i < n; i++) begin
      r = $urandom_range(99);
      value = DATA_W'($urandom_range(255));
      if (r < pw) send_beat(ubrf_pkg::CMD_HOST_WRITE, value);
      else if (r < pw + pr) send_beat(ubrf_pkg::CMD_HOST_READ, value);
      else if (r < pw + pr + prx) send_beat(ubrf_pkg::CMD_RX_BYTE, value);
      else send_beat(ubrf_pkg::CMD_TX_READY, value);
    end
  endtask

  // Empty rings, byte extremes, the enable going up and down.
  task automatic test_directed();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_beat(ubrf_pkg::CMD_HOST_READ, 8'hA5);
    send_beat(ubrf_pkg::CMD_TX_READY, 8'h00);
    send_beat(ubrf_pkg::CMD_HOST_WRITE, 8'h00);
    send_beat(ubrf_pkg::CMD_HOST_WRITE, 8'hFF);
    send_beat(ubrf_pkg::CMD_TX_READY, 8'hFF);
    send_beat(ubrf_pkg::CMD_TX_READY, 8'h55);
    send_beat(ubrf_pkg::CMD_TX_READY, 8'h00);
    send_beat(ubrf_pkg::CMD_TX_READY, 8'hFF);
    send_beat(ubrf_pkg::CMD_RX_BYTE, 8'h00);
    send_beat(ubrf_pkg::CMD_RX_BYTE, 8'hFF);
    send_beat(ubrf_pkg::CMD_RX_BYTE, 8'h5A);
    send_beat(ubrf_pkg::CMD_HOST_READ, 8'h00);
    send_beat(ubrf_pkg::CMD_HOST_READ, 8'hFF);
    send_beat(ubrf_pkg::CMD_HOST_READ, 8'h00);
    send_beat(ubrf_pkg::CMD_HOST_READ, 8'h3C);
    send_beat(ubrf_pkg::CMD_HOST_WRITE, 8'h81);
    send_beat(ubrf_pkg::CMD_RX_BYTE, 8'h7E);
    send_beat(ubrf_pkg::CMD_TX_READY, 8'hC3);
    send_beat(ubrf_pkg::CMD_HOST_READ, 8'h18);
    send_beat(ubrf_pkg::CMD_TX_READY, 8'h00);
  endtask

  // Fill the transmit ring past full, then drain it past empty.
  task automatic test_tx_full();
    send_idle_pct = IDLE_PCT;
    recv_idle_pct = IDLE_PCT;
    run_mix(FIFO_DEPTH + 2, 100, 0, 0);
    run_mix(FIFO_DEPTH + 2, 0, 0, 0);
  endtask

  // Fill the receive ring past full, then read it past empty.
  task automatic test_rx_full();
    send_idle_pct = IDLE_PCT;
    recv_idle_pct = IDLE_PCT;
    run_mix(FIFO_DEPTH + 2, 0, 0, 100);
    run_mix(FIFO_DEPTH + 2, 0, 100, 0);
  endtask

  // The output side holds off while beats keep coming, so the input must stall.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request = 1'b1;
    run_mix(16, 30, 20, 30);
  endtask

  // Random traffic, with a long stretch without idle gaps in the middle.
  task automatic test_random_mix();
    send_idle_pct = IDLE_PCT;
    recv_idle_pct = IDLE_PCT;
    run_mix(40, 40, 10, 10);
    run_mix(30, 10, 40, 40);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_mix(50, 25, 25, 25);
    send_idle_pct = IDLE_PCT;
    recv_idle_pct = IDLE_PCT;
    run_mix(30, 30, 20, 30);
  endtask

  // Output ready: random idle gaps, or a counted hold-off on request.
  always @(negedge clk) begin
    if (hold_request) begin
      hold_left = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !(recv_idle_pct != 0 && $urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic check_field(input string field, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, field, want, got);
    end
  endtask

  // Compare every status beat against the oldest prediction.
  always @(posedge clk) begin : check_status
    ring_status_t want;
    if (!rst && in_valid && !in_ready) stall_cycles++;
    if (!rst && out_valid && out_ready) begin
      if (status_due.size() == 0) begin
        mismatch_count++;
        $display("%0t: status beat with none expected, expected nothing, actual %0h",
                 $realtime, {accepted, read_byte, send_valid, send_byte,
                             tx_irq_enable, rx_available, rx_dropped});
      end else begin
        want = status_due.pop_front();
        status_checked++;
        check_field("accepted", want.accepted, accepted);
        check_field("read_byte", want.read_byte, read_byte);
        check_field("send_valid", want.send_valid, send_valid);
        check_field("send_byte", want.send_byte, send_byte);
        check_field("tx_irq_enable", want.tx_irq_enable, tx_irq_enable);
        check_field("rx_available", want.rx_available, rx_available);
        check_field("rx_dropped", want.rx_dropped, rx_dropped);
      end
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("%0t: run limit of %0d cycles reached, %0d status beats outstanding",
               $realtime, LIMIT_CYCLES, status_due.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    wait_until_drained();
    test_tx_full();
    wait_until_drained();
    test_rx_full();
    wait_until_drained();
    test_backpressure();
    wait_until_drained();
    test_random_mix();
    wait_until_drained();
    $display("Sent %0d command beats and checked %0d status beats in %0d cycles.",
             beats_sent, status_checked, cycle_count);
    $display("Saw %0d rejected host writes, %0d dropped line bytes, %0d input stall cycles.",
             tx_rejects, rx_drops, stall_cycles);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/ubrf_pkg.sv
rtl/ubrf_ram.sv
rtl/ubrf_ctrl.sv
rtl/ubrf_datapath.sv
rtl/uart_buffered_ring_fifos_unit.sv
tb/tb.sv
